// ===== rtl/core/b2ds_pkg.sv =====
// ----------------------------------------------------------------------------
// b2ds_pkg: shared constants for the 2x2 binning display stretch
// Register indexes, request codes, fixed field widths and the height limit.
// ----------------------------------------------------------------------------
`default_nettype none
package b2ds_pkg;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA  = 3'd4;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    localparam int SUM_W  = 19;
    localparam int PAIR_W = 17;
    localparam int HEIGHT_LIMIT = 4096;
endpackage
`default_nettype wire

// ===== rtl/core/b2ds_ram.sv =====
// ----------------------------------------------------------------------------
// b2ds_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module b2ds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/b2ds_div.sv =====
// ----------------------------------------------------------------------------
// b2ds_div: radix-2 restoring divider
// Unsigned quotient of num / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module b2ds_div #(
    parameter int NW = 32,
    parameter int DW = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quot_reg, quot_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], quot_reg[NW-1]};
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next     = trial - {1'b0, den_reg};
                quot_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// ===== rtl/core/bin2x2_display_stretch_core.sv =====
// ----------------------------------------------------------------------------
// bin2x2_display_stretch_core: 2x2 binning with linear or gamma stretch
// Sums 2x2 pixel blocks through a pair-sum line RAM and maps each bin sum
// to an 8-bit display value via a divider and a gamma table RAM.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+-------------------------------------------
//  in      | in_valid/in_stall | req_type pixel_value frame_start
//          |                   | table_index table_value
//  out     | out_valid/out_stall | gray_level frame_end
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// Pixels that do not finish a bin, and table writes, do not hold the input.
// A pixel that finishes a bin (odd column of an odd row) holds the input
// through the line RAM read, a multiply step, the divider start, the
// restoring divider, a gamma table RAM read, and the output register load.
// A bin that needs no division (clamped index, white level zero) skips the
// divider start and the divider. The result shows in the same cycle that
// the input is released. Reset clears position, held pixel, sequencer and
// output valid and sets the configuration registers to their defaults; the
// RAMs are not cleared. A stalled result holds in the output register; the
// input stays held in the load step until that register drains.
`default_nettype none
module bin2x2_display_stretch_core #(
    parameter int MAX_WIDTH        = 4096,
    parameter int GAMMA_INDEX_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] pixel_value,
    input  wire logic        frame_start,
    input  wire logic [9:0]  table_index,
    input  wire logic [7:0]  table_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  gray_level,
    output logic             frame_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [b2ds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    import b2ds_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LA_W   = $clog2(LINE_DEPTH);
    localparam int TSIZE  = 1 << GAMMA_INDEX_BITS;
    localparam int IMAX   = TSIZE - 1;
    localparam int CW     = (MAX_WIDTH > 8192) ? 16 : 14;
    // covers sum*255 and 2*num*IMAX + den
    localparam int NW     = SUM_W + ((GAMMA_INDEX_BITS > 8) ? GAMMA_INDEX_BITS : 8);
    localparam int DW     = 20;

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_TAB  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;
    localparam logic [2:0] ST_TOUT = 3'd6;

    // configuration registers
    logic [12:0] width_reg, height_reg;
    logic [15:0] black_reg, white_reg;
    logic        gamma_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            black_reg  <= '0;
            white_reg  <= 16'hFFFF;
            gamma_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_HEIGHT: height_reg <= cfg_data[12:0];
                REG_BLACK:  black_reg  <= cfg_data;
                REG_WHITE:  white_reg  <= cfg_data;
                REG_GAMMA:  gamma_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // saturated frame size
    logic [CW-1:0] w_use, h_use;
    always_comb
    begin
        w_use = CW'(width_reg);
        if (w_use < CW'(2)) w_use = CW'(2);
        if (w_use > CW'(MAX_WIDTH)) w_use = CW'(MAX_WIDTH);
        h_use = CW'(height_reg);
        if (h_use < CW'(2)) h_use = CW'(2);
        if (h_use > CW'(HEIGHT_LIMIT)) h_use = CW'(HEIGHT_LIMIT);
    end

    // position tracking
    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    logic [CW-1:0] x, y;
    logic [15:0]   held_reg;
    logic [2:0]    st_reg, st_next;
    logic          out_full_reg;
    logic          accept, pix_acc, tab_acc, bin_fire;
    logic [PAIR_W-1:0] pair;
    logic          last;

    always_comb
    begin
        x = frame_start ? '0 : col_reg;
        y = frame_start ? '0 : row_reg;
        if (x >= w_use)
        begin
            x = '0;
            y = y + CW'(1);
        end
        if (y >= h_use) y = '0;
        col_next = x + CW'(1);
        row_next = y;
        if (col_next >= w_use)
        begin
            col_next = '0;
            row_next = y + CW'(1);
            if (row_next >= h_use) row_next = '0;
        end
    end

    assign pair = PAIR_W'(held_reg) + PAIR_W'(pixel_value);
    assign last = (x == ((w_use & ~CW'(1)) - CW'(1)))
               && (y == ((h_use & ~CW'(1)) - CW'(1)));

    // a bin in flight, or one waiting behind a full output, holds the input
    assign in_stall = (st_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign tab_acc  = accept && (req_type == REQ_TABLE);
    assign pix_acc  = accept && (req_type == REQ_PIXEL);
    assign bin_fire = pix_acc && x[0] && y[0] && ((x >> 1) < CW'(LINE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!x[0]) held_reg <= pixel_value;
        end
    end

    // pair-sum line RAM
    logic [PAIR_W-1:0] line_rdata;
    logic [LA_W-1:0]   slot;
    assign slot = LA_W'(x >> 1);

    b2ds_ram #(.WIDTH(PAIR_W), .DEPTH(LINE_DEPTH)) u_line (
        .clk   (clk),
        .we    (pix_acc && x[0] && !y[0] && ((x >> 1) < CW'(LINE_DEPTH))),
        .waddr (slot),
        .wdata (pair),
        .raddr (slot),
        .rdata (line_rdata)
    );

    // bin context held while the mapper works
    logic [PAIR_W-1:0] pair_reg;
    logic              last_reg;
    logic              gmode_reg;
    logic [7:0]        lin_reg;
    logic [GAMMA_INDEX_BITS-1:0] idx_reg;
    logic              quick_reg;
    logic [NW-1:0]     div_num;
    logic [DW-1:0]     div_den;
    logic              div_start, div_done;
    logic [NW-1:0]     div_quot;

    logic [SUM_W-1:0]  sum_c, lo_c;
    logic [DW-1:0]     den_g;
    logic [SUM_W-1:0]  num_g;
    logic              gm_c;
    assign sum_c = SUM_W'(line_rdata) + SUM_W'(pair_reg);
    assign lo_c  = {1'b0, black_reg, 2'b00};
    assign den_g = DW'({white_reg - black_reg, 2'b00});
    assign num_g = sum_c - lo_c;
    assign gm_c  = gamma_reg && (black_reg < white_reg);

    always_ff @(posedge clk)
    begin
        if (bin_fire)
        begin
            pair_reg <= pair;
            last_reg <= last;
        end
        if (st_reg == ST_READ)
        begin
            gmode_reg <= gm_c;
            quick_reg <= 1'b0;
            if (gm_c)
            begin
                if (sum_c <= lo_c)
                begin
                    idx_reg   <= '0;
                    quick_reg <= 1'b1;
                end
                else if (SUM_W'(num_g) >= SUM_W'(den_g))
                begin
                    idx_reg   <= GAMMA_INDEX_BITS'(IMAX);
                    quick_reg <= 1'b1;
                end
                div_num <= NW'(num_g);
                div_den <= den_g;
            end
            else
            begin
                if (white_reg == '0)
                begin
                    lin_reg   <= (sum_c != '0) ? 8'd255 : 8'd0;
                    quick_reg <= 1'b1;
                end
                div_num <= NW'(sum_c);
                div_den <= DW'({white_reg, 2'b00});
            end
        end
        else if (st_reg == ST_PREP)
        begin
            // one multiply step ahead of the divider
            if (gmode_reg)
            begin
                div_num <= NW'((div_num * NW'(2 * IMAX)) + NW'(div_den));
                div_den <= DW'(div_den);
            end
            else
            begin
                div_num <= NW'(div_num * NW'(255));
            end
        end
        else if ((st_reg == ST_DIV) && div_done)
        begin
            if (gmode_reg)
                idx_reg <= GAMMA_INDEX_BITS'(div_quot);
            else
                lin_reg <= (div_quot > NW'(255)) ? 8'd255 : 8'(div_quot);
        end
    end

    // gamma divides by 2*den; the shift is folded into the start
    logic [DW:0] den2;
    assign den2 = {div_den, 1'b0};

    b2ds_div #(.NW(NW), .DW(DW + 1)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (gmode_reg ? den2 : {1'b0, div_den}),
        .done  (div_done),
        .quot  (div_quot)
    );
    assign div_start = (st_reg == ST_TOUT);

    // gamma table RAM
    logic [7:0] tab_rdata;
    b2ds_ram #(.WIDTH(8), .DEPTH(TSIZE)) u_gamma (
        .clk   (clk),
        .we    (tab_acc),
        .waddr (GAMMA_INDEX_BITS'(table_index)),
        .wdata (table_value),
        .raddr (idx_reg),
        .rdata (tab_rdata)
    );

    // sequencer: READ -> PREP -> TOUT(start) -> DIV -> TAB -> LOAD, or PREP -> TAB when no division is needed
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (bin_fire) st_next = ST_READ;
            ST_READ: st_next = ST_PREP;
            ST_PREP: st_next = quick_reg ? ST_TAB : ST_TOUT;
            ST_TOUT: st_next = ST_DIV;
            ST_DIV:  if (div_done) st_next = ST_TAB;
            ST_TAB:  st_next = ST_LOAD;
            ST_LOAD: if (!out_full_reg || !out_stall) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // output register
    logic [7:0] gray_reg;
    logic       fend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if ((st_reg == ST_LOAD) && (!out_full_reg || !out_stall))
                out_full_reg <= 1'b1;
            else if (!out_stall)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((st_reg == ST_LOAD) && (!out_full_reg || !out_stall))
        begin
            gray_reg <= gmode_reg ? tab_rdata : lin_reg;
            fend_reg <= last_reg;
        end
    end

    assign out_valid  = out_full_reg;
    assign gray_level = gray_reg;
    assign frame_end  = fend_reg;

    // the input stays held whenever a bin is in flight
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> in_stall)
        else $error("input taken during bin");
    // a bin start always leads to the line read
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        bin_fire |=> (st_reg == ST_READ))
        else $error("bin start lost");
    // a stalled result is not dropped from the output
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
endmodule
`default_nettype wire
